@@ rtl/bounded_signed_random_generator_top_macros.svh @@
// Assertion macros used by the top module to check its own logic.
`ifndef BOUNDED_SIGNED_RANDOM_GENERATOR_TOP_MACROS_SVH
`define BOUNDED_SIGNED_RANDOM_GENERATOR_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BSRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define BSRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bsrg_pkg.sv @@
package bsrg_pkg;

  localparam int SEED_W  = 31;
  localparam int VALUE_W = 32;
  localparam int SHIFT_W = 5;

  localparam logic [SEED_W-1:0] LCG_MUL    = 31'd1103515245;
  localparam logic [SEED_W-1:0] LCG_INC    = 31'd12345;
  localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;
  localparam logic [SEED_W-1:0] BOUND_MAX  = 31'h4000_0000;

  typedef logic [SEED_W-1:0]  seed_t;
  typedef logic [SHIFT_W-1:0] shift_t;
  typedef logic [VALUE_W-1:0] value_t;

endpackage

@@ rtl/bounded_signed_random_generator_top.sv @@
// Returns a pseudo-random signed value in the range from minus bound to plus bound for each
// bound received, using a 31-bit linear congruential generator and rejection sampling. An item
// passes a load step, a setup step that finds the draw width and makes the first generator
// step, one check step per draw (none for a zero bound), and a finish step that forms the signed
// result once the output register is free. Fewer than two draws are needed on average. A single
// constant multiply-add unit advances the generator, once in setup and once per draw. The input is
// not ready while an item is in work, and the result waits in an output register until it is taken.
// Bounds above 2^30 are treated as 2^30.
`include "bounded_signed_random_generator_top_macros.svh"

module bounded_signed_random_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] bound, [31] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] value
);
  import bsrg_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SETUP  = 2'd1;
  localparam logic [1:0] ST_CHECK  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  seed_t      seed;
  seed_t      bound;
  shift_t     sh;
  seed_t      draw;

  seed_t      seed_adv;
  shift_t     span_sh;
  seed_t      bound_in;
  seed_t      draw_cand;
  value_t     value_mag;
  value_t     value;

  bsrg_lcg u_lcg (
    .seed      (seed),
    .seed_next (seed_adv)
  );

  bsrg_span u_span (
    .bound (bound),
    .sh    (span_sh)
  );

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    bound_in  = (s_axis_tdata[30:0] > BOUND_MAX) ? BOUND_MAX : s_axis_tdata[30:0];
    draw_cand = seed >> sh;
    value_mag = {1'b0, draw};
    value     = seed[SEED_W-1] ? value_mag : (~value_mag + value_t'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      seed          <= SEED_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            bound <= bound_in;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          sh   <= span_sh;
          seed <= seed_adv;
          if (bound == '0) begin
            draw  <= '0;
            state <= ST_FINISH;
          end else begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          seed <= seed_adv;
          if (draw_cand <= bound) begin
            draw  <= draw_cand;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= value;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BSRG_ASSERT_NEXT(a_accept_setup, s_axis_tvalid && s_axis_tready,
                    state == ST_SETUP, "accepted transfer did not start setup")
  `BSRG_ASSERT(a_check_nonzero, state != ST_CHECK || bound != '0,
               "draw loop entered with zero bound")
  `BSRG_ASSERT(a_check_shift,
               state != ST_CHECK || (sh >= shift_t'(1) && sh <= shift_t'(30)),
               "draw shift out of range")
  `BSRG_ASSERT(a_finish_draw, state != ST_FINISH || draw <= bound,
               "draw exceeds bound at result")

endmodule

@@ rtl/bsrg_lcg.sv @@
module bsrg_lcg (
  input  bsrg_pkg::seed_t seed,
  output bsrg_pkg::seed_t seed_next
);
  import bsrg_pkg::*;

  // Only the low 31 bits of the product and sum are kept.
  assign seed_next = seed * LCG_MUL + LCG_INC;

endmodule

@@ rtl/bsrg_span.sv @@
module bsrg_span (
  input  bsrg_pkg::seed_t  bound,
  output bsrg_pkg::shift_t sh
);
  import bsrg_pkg::*;

  seed_t  bm1;
  shift_t len;
  shift_t n;

  // The bit length of bound minus one is the smallest n with 2^n not below bound.
  always_comb begin
    bm1 = bound - seed_t'(1);
    len = '0;
    for (int i = 0; i < SEED_W; i++) begin
      if (bm1[i]) begin
        len = shift_t'(i + 1);
      end
    end
    n  = (bound <= seed_t'(1)) ? shift_t'(1) : len;
    sh = shift_t'(SEED_W) - n;
  end

endmodule
